// ----- rtl/gbts_pkg.sv -----
package gbts_pkg;

    localparam int CAPACITY_DEFAULT = 1024;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 11;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_MOVE
    } state_t;

endpackage

// ----- rtl/gbts_if.sv -----
interface gbts_req_if;
    import gbts_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [POS_W-1:0]    position;
    logic [CHAR_W-1:0]   char_value;
    logic [POS_W-1:0]    delete_count;

    modport source (output valid, output func, output position, output char_value,
                    output delete_count, input ready);
    modport sink (input valid, input func, input position, input char_value,
                  input delete_count, output ready);
endinterface

interface gbts_rsp_if;
    import gbts_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   read_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink (input valid, input read_value, input status, output ready);
endinterface

// ----- rtl/gap_buffer_text_store_core.sv -----
// Gap buffer holding up to CAPACITY text bytes, with one request and one
// response channel (valid/ready). Each request item carries an operation:
// insert a byte at a position, delete delete_count bytes just before a
// position, or read the byte at a position. Every request gives exactly one
// response item with read_value and status.
// A read is checked, then fetched from the registered text RAM, then
// answered. Insert and delete first bring the gap to the position: the
// gap is moved by a copy loop through the single text RAM, one byte per
// cycle, with the read of the next byte overlapping the write of the
// previous one.
// Rejected requests (full, out of range, unused operation) answer from the
// check step. Only one request is in progress at a time; ready is high only
// while the block is idle, from the cycle after a response is registered.
// The response sits in an output register, so a new request is accepted
// while the previous response waits; if the receiver still stalls when the
// next response is ready, the block holds in its current step until the
// register frees up.
// Reset empties the text (gap spans the whole memory) and drops any
// pending response. The text RAM itself is not cleared.
module gap_buffer_text_store_core #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    gbts_req_if.sink   req,
    gbts_rsp_if.source rsp
);
    import gbts_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int GW = $clog2(CAPACITY + 1);
    localparam int CW = (GW > POS_W) ? GW : POS_W;

    state_t state_reg, state_next;

    logic [FUNC_W-1:0]   func_reg;
    logic [CW-1:0]       pos_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic [CW-1:0]       cnt_reg;

    logic [GW-1:0]       gap_low_reg, gap_low_next;
    logic [GW-1:0]       gap_high_reg, gap_high_next;
    logic [GW-1:0]       cursor_reg, cursor_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [AW-1:0]       wr_addr_reg, wr_addr_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [CHAR_W-1:0]   rsp_value_reg, rsp_value_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [CHAR_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [CHAR_W-1:0]   ram_rdata;

    logic [GW-1:0]       span;
    logic [CW-1:0]       text_len;
    logic [GW-1:0]       pos_g;
    logic [GW-1:0]       cur_dec;
    logic [GW-1:0]       cur_dec_hi;
    logic [GW-1:0]       cur_hi;
    logic [GW-1:0]       pos_hi;
    logic                slot_free;
    logic                accept;
    logic                reject;
    logic [STATUS_W-1:0] reject_code;

    gbts_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign span       = gap_high_reg - gap_low_reg;
    assign text_len   = CW'(CAPACITY) - CW'(span);
    assign pos_g      = pos_reg[GW-1:0];
    assign cur_dec    = cursor_reg - GW'(1);
    assign cur_dec_hi = cur_dec + span;
    assign cur_hi     = cursor_reg + span;
    assign pos_hi     = pos_g + span;
    assign slot_free  = !rsp_valid_reg || rsp.ready;
    assign accept     = req.valid && req.ready;

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rsp_value_reg;
    assign rsp.status     = rsp_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gap_low_reg   <= '0;
            gap_high_reg  <= GW'(CAPACITY);
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gap_low_reg   <= gap_low_next;
            gap_high_reg  <= gap_high_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            pos_reg  <= CW'(req.position);
            char_reg <= req.char_value;
            cnt_reg  <= CW'(req.delete_count);
        end
        cursor_reg     <= cursor_next;
        wr_addr_reg    <= wr_addr_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_status_reg <= rsp_status_next;
    end

    // Decide in the check step whether the request is rejected.
    always_comb
    begin
        reject      = 1'b0;
        reject_code = ST_RANGE;
        unique case (func_reg)
            FN_INSERT:
            begin
                if (pos_reg > text_len)
                begin
                    reject = 1'b1;
                end
                else if (span == '0)
                begin
                    reject      = 1'b1;
                    reject_code = ST_FULL;
                end
            end
            FN_DELETE:
            begin
                reject = (pos_reg > text_len) || (cnt_reg > pos_reg);
            end
            FN_READ:
            begin
                reject = (pos_reg >= text_len);
            end
            default:
            begin
                reject = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        gap_low_next    = gap_low_reg;
        gap_high_next   = gap_high_reg;
        cursor_next     = cursor_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_value_next  = rsp_value_reg;
        rsp_status_next = rsp_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_addr_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (reject)
                begin
                    if (slot_free)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_value_next  = '0;
                        rsp_status_next = reject_code;
                        state_next      = S_IDLE;
                    end
                end
                else if (func_reg == FN_READ)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = (pos_g < gap_low_reg) ? pos_g[AW-1:0] : pos_hi[AW-1:0];
                    state_next = S_READ;
                end
                else
                begin
                    cursor_next  = gap_low_reg;
                    wr_pend_next = 1'b0;
                    state_next   = S_MOVE;
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = ram_rdata;
                    rsp_status_next = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_MOVE:
            begin
                // The byte fetched last cycle lands on the far side of the gap.
                if (wr_pend_reg)
                begin
                    ram_we       = 1'b1;
                    wr_pend_next = 1'b0;
                end
                priority if (pos_g < cursor_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = cur_dec[AW-1:0];
                    wr_addr_next = cur_dec_hi[AW-1:0];
                    wr_pend_next = 1'b1;
                    cursor_next  = cur_dec;
                end
                else if (pos_g > cursor_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = cur_hi[AW-1:0];
                    wr_addr_next = cursor_reg[AW-1:0];
                    wr_pend_next = 1'b1;
                    cursor_next  = cursor_reg + GW'(1);
                end
                else if (!wr_pend_reg && slot_free)
                begin
                    gap_high_next = pos_hi;
                    if (func_reg == FN_INSERT)
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = pos_g[AW-1:0];
                        ram_wdata    = char_reg;
                        gap_low_next = pos_g + GW'(1);
                    end
                    else
                    begin
                        gap_low_next = pos_g - cnt_reg[GW-1:0];
                    end
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = '0;
                    rsp_status_next = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/gbts_ram.sv -----
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/gbts_checker.sv -----
module gbts_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [gbts_pkg::CHAR_W-1:0]   rsp_read_value,
    input logic [gbts_pkg::STATUS_W-1:0] rsp_status
);
    import gbts_pkg::*;

    // Work on one item at a time: the block is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a previous item was still in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
                                    && $stable(rsp_status))
        else $error("stalled response changed or vanished");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_FULL)
                      || (rsp_status == ST_RANGE))
        else $error("response carries an unknown status code");

    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> rsp_read_value == '0)
        else $error("failed operation returned a non-zero byte");
endmodule

bind gap_buffer_text_store_core gbts_checker u_gbts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_value (rsp.read_value),
    .rsp_status     (rsp.status)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import gbts_pkg::*;

    localparam int CAP = CAPACITY_DEFAULT;
    localparam int N_DIRECTED = 26;
    localparam int N_EDITS = 500;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [POS_W-1:0]    position;
        logic [CHAR_W-1:0]   char_value;
        logic [POS_W-1:0]    delete_count;
        logic                fixed;
        logic [CHAR_W-1:0]   read_value;
        logic [STATUS_W-1:0] status;
    } edit_row_t;

    typedef struct packed {
        logic [CHAR_W-1:0]   read_value;
        logic [STATUS_W-1:0] status;
    } edit_answer_t;

    logic clk = 1'b0;
    logic rst_n;
    logic steady = 1'b0;

    gbts_req_if req_ch ();
    gbts_rsp_if rsp_ch ();

    gap_buffer_text_store_core #(
        .CAPACITY(CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // Logical text as the user sees it; the gap itself is not observable.
    logic [CHAR_W-1:0] text_q [$];
    edit_answer_t      answers_due [$];

    int errors;
    int items_sent;
    int answers_seen;
    int n_ok;
    int n_full;
    int n_range;
    int cursor;

    // Rows marked fixed carry their answer; the others are worked out from the text.
    edit_row_t directed_rows [N_DIRECTED] = '{
        '{FN_READ,   11'd0,    8'h00, 11'd0,    1'b1, 8'h00, ST_RANGE},
        '{FN_DELETE, 11'd0,    8'h00, 11'd0,    1'b1, 8'h00, ST_OK},
        '{FN_INSERT, 11'd1,    8'h41, 11'd0,    1'b1, 8'h00, ST_RANGE},
        '{FN_UNUSED, 11'd2047, 8'hFF, 11'd2047, 1'b1, 8'h00, ST_RANGE},
        '{FN_INSERT, 11'd0,    8'h00, 11'd0,    1'b1, 8'h00, ST_OK},
        '{FN_INSERT, 11'd1,    8'hFF, 11'd0,    1'b1, 8'h00, ST_OK},
        '{FN_INSERT, 11'd0,    8'h5A, 11'd0,    1'b0, 8'h00, ST_OK},
        '{FN_INSERT, 11'd3,    8'hA5, 11'd0,    1'b0, 8'h00, ST_OK},
        '{FN_READ,   11'd0,    8'h00, 11'd0,    1'b0, 8'h00, ST_OK},
        '{FN_READ,   11'd1,    8'h00, 11'd0,    1'b0, 8'h00, ST_OK},
        '{FN_READ,   11'd2,    8'h00, 11'd0,    1'b0, 8'h00, ST_OK},
        '{FN_READ,   11'd3,    8'h00, 11'd0,    1'b0, 8'h00, ST_OK},
        '{FN_READ,   11'd4,    8'h00, 11'd0,    1'b1, 8'h00, ST_RANGE},
        '{FN_READ,   11'd2047, 8'h00, 11'd0,    1'b1, 8'h00, ST_RANGE},
        '{FN_DELETE, 11'd2,    8'h00, 11'd3,    1'b1, 8'h00, ST_RANGE},
        '{FN_DELETE, 11'd5,    8'h00, 11'd0,    1'b1, 8'h00, ST_RANGE},
        '{FN_DELETE, 11'd2047, 8'h00, 11'd2047, 1'b1, 8'h00, ST_RANGE},
        '{FN_DELETE, 11'd4,    8'h00, 11'd0,    1'b1, 8'h00, ST_OK},
        '{FN_DELETE, 11'd3,    8'h00, 11'd2,    1'b0, 8'h00, ST_OK},
        '{FN_READ,   11'd0,    8'h00, 11'd0,    1'b0, 8'h00, ST_OK},
        '{FN_READ,   11'd1,    8'h00, 11'd0,    1'b0, 8'h00, ST_OK},
        '{FN_INSERT, 11'd2047, 8'h33, 11'd0,    1'b1, 8'h00, ST_RANGE},
        '{FN_DELETE, 11'd2,    8'h00, 11'd2,    1'b1, 8'h00, ST_OK},
        '{FN_READ,   11'd0,    8'h00, 11'd0,    1'b1, 8'h00, ST_RANGE},
        '{FN_INSERT, 11'd0,    8'h80, 11'd0,    1'b0, 8'h00, ST_OK},
        '{FN_READ,   11'd0,    8'h00, 11'd0,    1'b0, 8'h00, ST_OK}
    };

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic edit_answer_t apply_edit(input logic [FUNC_W-1:0] func,
                                                input logic [POS_W-1:0] position,
                                                input logic [CHAR_W-1:0] char_value,
                                                input logic [POS_W-1:0] delete_count);
        edit_answer_t answer;
        int len;
        int pos;
        int cnt;
        len = text_q.size();
        pos = int'(position);
        cnt = int'(delete_count);
        answer.read_value = '0;
        answer.status = ST_OK;
        case (func)
            FN_INSERT:
            begin
                // The position is checked before the free space.
                if (pos > len)
                    answer.status = ST_RANGE;
                else if (len == CAP)
                    answer.status = ST_FULL;
                else if (pos == len)
                    text_q.push_back(char_value);
                else
                    text_q.insert(pos, char_value);
            end
            FN_DELETE:
            begin
                if (pos > len || cnt > pos)
                    answer.status = ST_RANGE;
                else
                    repeat (cnt) text_q.delete(pos - cnt);
            end
            FN_READ:
            begin
                if (pos >= len)
                    answer.status = ST_RANGE;
                else
                    answer.read_value = text_q[pos];
            end
            default:
                answer.status = ST_RANGE;
        endcase
        return answer;
    endfunction

    function automatic edit_row_t make_row(input logic [FUNC_W-1:0] func, input int pos,
                                           input int char_value, input int cnt);
        edit_row_t row;
        row = '0;
        row.func = func;
        row.position = POS_W'(pos);
        row.char_value = CHAR_W'(char_value);
        row.delete_count = POS_W'(cnt);
        return row;
    endfunction

    // Valid is only lowered for an idle cycle, so it never gets two updates in one step.
    task automatic send_item(input edit_row_t row);
        edit_answer_t due;
        while (!steady && $urandom_range(99) < 22)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= row.func;
        req_ch.position     <= row.position;
        req_ch.char_value   <= row.char_value;
        req_ch.delete_count <= row.delete_count;
        do
            @(posedge clk);
        while (!req_ch.ready);
        due = apply_edit(row.func, row.position, row.char_value, row.delete_count);
        if (row.fixed)
        begin
            due.read_value = row.read_value;
            due.status = row.status;
        end
        answers_due.push_back(due);
        items_sent++;
    endtask

    // Editing mostly happens close to the cursor, as it would in an editor.
    task automatic send_random_edit();
        int len;
        int pos;
        int cnt;
        int kind;
        int lo;
        int hi;
        len = text_q.size();
        if (cursor > len)
            cursor = len;
        lo = (cursor > 4) ? cursor - 4 : 0;
        hi = (cursor + 4 < len) ? cursor + 4 : len;
        if ($urandom_range(99) < 80)
            pos = $urandom_range(hi, lo);
        else
            pos = $urandom_range(len, 0);
        kind = $urandom_range(99);
        if (kind < 45)
        begin
            send_item(make_row(FN_INSERT, pos, $urandom_range(255, 0), 0));
            cursor = pos + 1;
        end
        else if (kind < 65)
        begin
            if ($urandom_range(9) == 0)
                cnt = $urandom_range(pos, 0);
            else
                cnt = $urandom_range((pos < 3) ? pos : 3, 0);
            send_item(make_row(FN_DELETE, pos, $urandom_range(255, 0), cnt));
            cursor = pos - cnt;
        end
        else if (kind < 93)
        begin
            if (pos == len && len > 0 && $urandom_range(3) != 0)
                pos = len - 1;
            send_item(make_row(FN_READ, pos, $urandom_range(255, 0), $urandom_range(2047, 0)));
        end
        else
        begin
            send_item(make_row(FUNC_W'($urandom_range(3, 0)), $urandom_range(2047, 0),
                               $urandom_range(255, 0), $urandom_range(2047, 0)));
        end
    endtask

    always @(posedge clk)
        rsp_ch.ready <= steady || ($urandom_range(99) >= 22);

    always @(posedge clk)
    begin : check_answers
        edit_answer_t due;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            answers_seen++;
            if (answers_due.size() == 0)
            begin
                $error("status: no item outstanding, got read_value %0h status %0d",
                       rsp_ch.read_value, rsp_ch.status);
                errors++;
            end
            else
            begin
                due = answers_due.pop_front();
                if (rsp_ch.read_value !== due.read_value)
                begin
                    $error("read_value: expected %0h, got %0h", due.read_value,
                           rsp_ch.read_value);
                    errors++;
                end
                if (rsp_ch.status !== due.status)
                begin
                    $error("status: expected %0d, got %0d", due.status, rsp_ch.status);
                    errors++;
                end
                case (due.status)
                    ST_OK:   n_ok++;
                    ST_FULL: n_full++;
                    default: n_range++;
                endcase
            end
        end
    end

    initial
    begin
        int len;
        int pos;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.func         <= FN_READ;
        req_ch.position     <= '0;
        req_ch.char_value   <= '0;
        req_ch.delete_count <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed_rows[i]);

        cursor = 0;
        for (int i = 0; i < N_EDITS; i++)
        begin
            steady <= (i >= 200 && i < 300);
            send_random_edit();
        end

        // Append until the buffer is full, with the odd read in between.
        while (text_q.size() < CAP)
        begin
            len = text_q.size();
            if ($urandom_range(15) == 0)
                send_item(make_row(FN_READ, $urandom_range(len, 0), 0, 0));
            else
                send_item(make_row(FN_INSERT, len, $urandom_range(255, 0), 0));
        end

        // Around the full mark: rejected inserts, long gap moves and refills.
        for (int i = 0; i < 40; i++)
        begin
            len = text_q.size();
            pos = $urandom_range(len, 0);
            case ($urandom_range(3, 0))
                0: send_item(make_row(FN_INSERT, $urandom_range(CAP + 8, 0),
                                      $urandom_range(255, 0), 0));
                1: send_item(make_row(FN_READ, $urandom_range(CAP, 0), 0, 0));
                2: send_item(make_row(FN_DELETE, pos, 0,
                                      $urandom_range((pos < 2) ? pos : 2, 0)));
                default: send_item(make_row(FN_INSERT, pos, $urandom_range(255, 0), 0));
            endcase
        end
        while (text_q.size() < CAP)
            send_item(make_row(FN_INSERT, $urandom_range(text_q.size(), 0),
                               $urandom_range(255, 0), 0));
        send_item(make_row(FN_INSERT, CAP, 8'h7E, 0));
        send_item(make_row(FN_READ, CAP - 1, 0, 0));
        send_item(make_row(FN_DELETE, CAP, 0, CAP));
        send_item(make_row(FN_READ, 0, 0, 0));
        req_ch.valid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("summary: %0d items (%0d directed), %0d answers: %0d ok, %0d full, %0d range",
                 items_sent, N_DIRECTED, answers_seen, n_ok, n_full, n_range);
        $display("summary: edits near the cursor, noise items, fill to %0d bytes and clear", CAP);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #80_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ----- gap_buffer_text_store_core.f -----
rtl/gbts_pkg.sv
rtl/gbts_if.sv
rtl/gbts_ram.sv
rtl/gap_buffer_text_store_core.sv
rtl/gbts_checker.sv
verif/testbench.sv
